// ===== hw/rtl/hppu_pkg.sv =====
// Shared constants and types for the homography point projector.
package hppu_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int Q_BITS        = 16;
    localparam int COEF_W        = 32;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_IDX_W     = 3;
    localparam int DIM_W         = 15;

    localparam logic [CFG_IDX_W-1:0] REG_ROW0_A      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW0B_ROW1A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_B      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_A      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_B      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_W     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_H     = 3'd6;

    localparam logic [COEF_W-1:0] H22_RESET     = 32'h0001_0000;
    localparam logic [DIM_W-1:0]  WIDTH_RESET   = 15'd640;
    localparam logic [DIM_W-1:0]  HEIGHT_RESET  = 15'd480;

    localparam logic signed [Q_BITS-1:0] Q_MAX = 16'sh7FFF;
    localparam logic signed [Q_BITS-1:0] Q_MIN = 16'sh8000;

    typedef struct packed {
        logic neg_num;
        logic neg;
        logic num_zero;
        logic den_zero;
        logic ovf;
    } div_flags_t;

endpackage

// ===== hw/rtl/homography_point_projector_unit.sv =====
// Top level: projects a lat/lon point through a 3x3 homography into pixel coordinates.
//
// channel  | dir | item
// s_       | in  | lat_q, lon_q
// m_       | out | pix_x, pix_y, in_view
// cfg_     | in  | register writes, no read-back
//
// One item per cycle while m_tready holds the output moving; stages: multiply, row sums, 18-stage divider, output.
// The divider's 17 compare/subtract steps set the depth.
// aresetn clears the valid bits and restores the register defaults.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
module homography_point_projector_unit #(
    parameter int FRAC_BITS = hppu_pkg::FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [63:0]                          s_tdata,  // lat_q[31:0], lon_q[63:32]
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [39:0]                          m_tdata,  // pix_x[15:0], pix_y[31:16], in_view[32]
    input  logic                                 cfg_we,
    input  logic [hppu_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hppu_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int CW    = hppu_pkg::COEF_W;
    localparam int QB    = hppu_pkg::Q_BITS;
    localparam int DW    = hppu_pkg::DIM_W;
    localparam int SUM_W = 66 - FRAC_BITS;
    localparam int PIPE  = QB + 4;

    logic [hppu_pkg::CFG_DATA_W-1:0] r0a_reg, r01_reg, r1b_reg, r2a_reg;
    logic [CW-1:0]                   h22_reg;
    logic [DW-1:0]                   fw_reg, fh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r0a_reg <= '0;
            r01_reg <= '0;
            r1b_reg <= '0;
            r2a_reg <= '0;
            h22_reg <= hppu_pkg::H22_RESET;
            fw_reg  <= hppu_pkg::WIDTH_RESET;
            fh_reg  <= hppu_pkg::HEIGHT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                hppu_pkg::REG_ROW0_A:      r0a_reg <= cfg_data;
                hppu_pkg::REG_ROW0B_ROW1A: r01_reg <= cfg_data;
                hppu_pkg::REG_ROW1_B:      r1b_reg <= cfg_data;
                hppu_pkg::REG_ROW2_A:      r2a_reg <= cfg_data;
                hppu_pkg::REG_ROW2_B:      h22_reg <= cfg_data[CW-1:0];
                hppu_pkg::REG_FRAME_W:     fw_reg  <= cfg_data[DW-1:0];
                hppu_pkg::REG_FRAME_H:     fh_reg  <= cfg_data[DW-1:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic m_tvalid_reg;
    logic [PIPE-1:0] vld_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            vld_reg      <= {vld_reg[PIPE-2:0], s_tvalid};
            m_tvalid_reg <= vld_reg[PIPE-1];
        end
    end

    logic signed [CW-1:0] lat, lon;
    assign lat = $signed(s_tdata[CW-1:0]);
    assign lon = $signed(s_tdata[2*CW-1:CW]);

    // stage 1: products
    logic signed [2*CW-1:0] p00_reg, p01_reg, p10_reg, p11_reg, p20_reg, p21_reg;
    logic signed [CW-1:0]   c0_reg, c1_reg, c2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p00_reg <= $signed(r0a_reg[2*CW-1:CW]) * lat;
            p01_reg <= $signed(r0a_reg[CW-1:0])    * lon;
            p10_reg <= $signed(r01_reg[CW-1:0])    * lat;
            p11_reg <= $signed(r1b_reg[2*CW-1:CW]) * lon;
            p20_reg <= $signed(r2a_reg[2*CW-1:CW]) * lat;
            p21_reg <= $signed(r2a_reg[CW-1:0])    * lon;
            c0_reg  <= $signed(r01_reg[2*CW-1:CW]);
            c1_reg  <= $signed(r1b_reg[CW-1:0]);
            c2_reg  <= $signed(h22_reg);
        end
    end

    // stage 2: row sums, products floored to FRAC_BITS fraction bits
    logic signed [SUM_W-1:0] s00, s01, s10, s11, s20, s21;
    logic signed [SUM_W-1:0] u_reg, v_reg, w_reg;

    assign s00 = SUM_W'(p00_reg >>> FRAC_BITS);
    assign s01 = SUM_W'(p01_reg >>> FRAC_BITS);
    assign s10 = SUM_W'(p10_reg >>> FRAC_BITS);
    assign s11 = SUM_W'(p11_reg >>> FRAC_BITS);
    assign s20 = SUM_W'(p20_reg >>> FRAC_BITS);
    assign s21 = SUM_W'(p21_reg >>> FRAC_BITS);

    always_ff @(posedge aclk) begin
        if (en) begin
            u_reg <= s00 + s01 + SUM_W'(c0_reg);
            v_reg <= s10 + s11 + SUM_W'(c1_reg);
            w_reg <= s20 + s21 + SUM_W'(c2_reg);
        end
    end

    logic signed [QB-1:0] qx, qy;
    logic                 okx, oky;

    hppu_divider #(.SUM_W(SUM_W)) u_div_x (
        .aclk (aclk),
        .en   (en),
        .num  (u_reg),
        .den  (w_reg),
        .quo  (qx),
        .ok   (okx)
    );

    hppu_divider #(.SUM_W(SUM_W)) u_div_y (
        .aclk (aclk),
        .en   (en),
        .num  (v_reg),
        .den  (w_reg),
        .quo  (qy),
        .ok   (oky)
    );

    logic in_view;
    assign in_view = okx && oky && !qx[QB-1] && !qy[QB-1]
                     && ($unsigned(qx) <= {1'b0, fw_reg})
                     && ($unsigned(qy) <= {1'b0, fh_reg});

    logic [39:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= {7'd0, in_view, qy, qx};
        end
    end

    assign m_tdata = m_tdata_reg;

endmodule

// ===== hw/rtl/hppu_divider.sv =====
// Pipelined restoring divider: signed quotient, truncated and saturated to 16 bits.
module hppu_divider #(
    parameter int SUM_W = 66 - hppu_pkg::FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              en,
    input  logic signed [SUM_W-1:0]           num,
    input  logic signed [SUM_W-1:0]           den,
    output logic signed [hppu_pkg::Q_BITS-1:0] quo,
    output logic                              ok
);

    localparam int QB    = hppu_pkg::Q_BITS;
    localparam int STEPS = QB + 1;
    localparam int CMP_W = SUM_W + STEPS;

    logic [CMP_W-1:0]          rem_reg   [0:STEPS-1];
    logic [SUM_W-1:0]          den_reg   [0:STEPS-1];
    logic [QB-1:0]             q_reg     [0:STEPS];
    hppu_pkg::div_flags_t      flags_reg [0:STEPS];

    logic [SUM_W-1:0] num_mag;
    logic [SUM_W-1:0] den_mag;

    assign num_mag = num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);
    assign den_mag = den[SUM_W-1] ? SUM_W'(-den) : SUM_W'(den);

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]   <= CMP_W'(num_mag);
            den_reg[0]   <= den_mag;
            q_reg[0]     <= '0;
            flags_reg[0] <= '{neg_num:  num[SUM_W-1],
                               neg:      num[SUM_W-1] ^ den[SUM_W-1],
                               num_zero: (num == '0),
                               den_zero: (den == '0),
                               ovf:      1'b0};
        end
    end

    for (genvar j = 0; j < STEPS; j++) begin : g_step
        localparam int SH = STEPS - 1 - j;
        logic [CMP_W-1:0] dsh;
        logic             ge;

        assign dsh = CMP_W'(den_reg[j]) << SH;
        assign ge  = (rem_reg[j] >= dsh);

        if (j < STEPS - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[j+1] <= ge ? (rem_reg[j] - dsh) : rem_reg[j];
                    den_reg[j+1] <= den_reg[j];
                end
            end
        end

        if (SH == QB) begin : g_ovf
            always_ff @(posedge aclk) begin
                if (en) begin
                    q_reg[j+1]     <= q_reg[j];
                    flags_reg[j+1] <= '{neg_num:  flags_reg[j].neg_num,
                                        neg:      flags_reg[j].neg,
                                        num_zero: flags_reg[j].num_zero,
                                        den_zero: flags_reg[j].den_zero,
                                        ovf:      ge};
                end
            end
        end else begin : g_bit
            always_ff @(posedge aclk) begin
                if (en) begin
                    q_reg[j+1]     <= q_reg[j] | (QB'(ge) << SH);
                    flags_reg[j+1] <= flags_reg[j];
                end
            end
        end
    end

    hppu_pkg::div_flags_t fl;
    logic [QB-1:0]        mag;

    assign fl  = flags_reg[STEPS];
    assign mag = q_reg[STEPS];

    always_comb begin
        quo = '0;
        ok  = 1'b1;
        priority if (fl.den_zero) begin
            ok = 1'b0;
            if (fl.num_zero) quo = '0;
            else quo = fl.neg_num ? hppu_pkg::Q_MIN : hppu_pkg::Q_MAX;
        end else if (fl.ovf) begin
            ok  = 1'b0;
            quo = fl.neg ? hppu_pkg::Q_MIN : hppu_pkg::Q_MAX;
        end else if (!fl.neg) begin
            if (mag[QB-1]) begin
                ok  = 1'b0;
                quo = hppu_pkg::Q_MAX;
            end else begin
                quo = $signed(mag);
            end
        end else begin
            if (mag > {1'b1, {(QB-1){1'b0}}}) begin
                ok  = 1'b0;
                quo = hppu_pkg::Q_MIN;
            end else begin
                quo = $signed(QB'(-mag));
            end
        end
    end

endmodule
